/* src/utf8s_pkg.sv */
// Shared types, constants and lead-byte decode for the UTF-8 sanitizer.
`timescale 1ns / 1ps

package utf8s_pkg;

	// Bytes of the inserted U+FFFD replacement character
	localparam logic [7:0] REPL_BYTE0 = 8'hEF;
	localparam logic [7:0] REPL_BYTE1 = 8'hBF;
	localparam logic [7:0] REPL_BYTE2 = 8'hBD;

	// Byte ranges
	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] CONT_LO    = 8'h80;
	localparam logic [7:0] CONT_HI    = 8'hBF;
	localparam logic [7:0] LEAD2_LO   = 8'hC2;
	localparam logic [7:0] LEAD2_HI   = 8'hDF;
	localparam logic [7:0] LEAD_E0    = 8'hE0;
	localparam logic [7:0] E0_CONT_LO = 8'hA0;
	localparam logic [7:0] LEAD_ED    = 8'hED;
	localparam logic [7:0] ED_CONT_HI = 8'h9F;
	localparam logic [7:0] LEAD3_HI   = 8'hEF;
	localparam logic [7:0] LEAD_F0    = 8'hF0;
	localparam logic [7:0] F0_CONT_LO = 8'h90;
	localparam logic [7:0] LEAD_F4    = 8'hF4;
	localparam logic [7:0] F4_CONT_HI = 8'h8F;

	// Sequence lengths
	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_TWO  = 3'd2;
	localparam logic [2:0] SEQ_THREE = 3'd3;
	localparam logic [2:0] SEQ_FOUR = 3'd4;

	// Position inside an emitted replacement character
	localparam logic [1:0] PHASE_FIRST = 2'd0;
	localparam logic [1:0] PHASE_MID   = 2'd1;
	localparam logic [1:0] PHASE_LAST  = 2'd2;

	// Lead-byte class: sequence length and allowed range of the first continuation
	typedef struct packed {
		logic [2:0] len;
		logic [7:0] lo;
		logic [7:0] hi;
	} lead_info_t;

	// Results of one item: rep_cnt replacement characters, then lit_cnt literal bytes
	typedef struct packed {
		logic [2:0]      rep_cnt;
		logic [2:0]      lit_cnt;
		logic [3:0][7:0] lits;
		logic            last;
	} item_desc_t;

	function automatic lead_info_t lead_info(logic [7:0] c);
		lead_info_t li;
		li.len = SEQ_NONE;
		li.lo  = CONT_LO;
		li.hi  = CONT_HI;
		if (c >= LEAD2_LO && c <= LEAD2_HI) begin
			li.len = SEQ_TWO;
		end else if (c == LEAD_E0) begin
			li.len = SEQ_THREE;
			li.lo  = E0_CONT_LO;
		end else if (c == LEAD_ED) begin
			li.len = SEQ_THREE;
			li.hi  = ED_CONT_HI;
		end else if (c > LEAD_E0 && c <= LEAD3_HI) begin
			li.len = SEQ_THREE;
		end else if (c == LEAD_F0) begin
			li.len = SEQ_FOUR;
			li.lo  = F0_CONT_LO;
		end else if (c == LEAD_F4) begin
			li.len = SEQ_FOUR;
			li.hi  = F4_CONT_HI;
		end else if (c > LEAD_F0 && c < LEAD_F4) begin
			li.len = SEQ_FOUR;
		end
		return li;
	endfunction

endpackage

/* src/utf8_sanitizer_top.sv */
// Top level of the streaming UTF-8 sanitizer.
//
// Input channel (in_valid / in_stall) takes one raw byte per item, with in_last
// on the final byte of a message. Output channel (out_valid / out_stall) gives
// one sanitized byte per item; is_replacement flags bytes of an inserted
// EF BF BD, last_of_run marks the final byte caused by one input byte and
// out_last the final byte of the message.
// An input byte yields 0 to 12 output bytes. The descriptor of its output is
// loaded into the result sequencer when the byte is accepted, and each byte then
// passes through the output register. The block sends one output byte per cycle
// while the receiver does not stall; plain text runs at one byte per cycle while
// the receiver does not stall. A byte that is only held (start of a multi-byte
// sequence) gives no output and does not occupy the result sequencer.
// Reset clears the held sequence, the sequencer and the output register.
// When the receiver stalls, the output register holds its byte, the sequencer
// waits, and in_stall rises once the sequencer is busy with a previous item.
`timescale 1ns / 1ps

module utf8_sanitizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_replacement,
	output logic       out_last,
	output logic       last_of_run
);

	utf8s_pkg::item_desc_t desc;
	logic                  desc_nonempty;
	logic                  can_load;
	logic                  accept;

	assign in_stall = !can_load;
	assign accept   = in_valid && can_load;

	// Track multi-byte sequences
	utf8s_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.desc          (desc),
		.desc_nonempty (desc_nonempty)
	);

	// Play out results
	utf8s_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (accept),
		.desc           (desc),
		.desc_nonempty  (desc_nonempty),
		.can_load       (can_load),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.is_replacement (is_replacement),
		.out_last       (out_last),
		.last_of_run    (last_of_run)
	);

endmodule

/* src/utf8s_decode.sv */
// Sequence tracker: holds pending bytes and turns each item into a result descriptor.
`timescale 1ns / 1ps

module utf8s_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	output utf8s_pkg::item_desc_t desc,
	output logic                  desc_nonempty
);

	logic [7:0] pending_bytes_q [3];
	logic [1:0] pending_count_q;
	logic [2:0] sequence_length_q;

	logic [1:0] next_count;
	logic [2:0] next_length;
	logic [2:0] wr_en;
	logic [2:0] rep_cnt;
	logic [2:0] lit_cnt;
	logic [3:0][7:0] lits;

	utf8s_pkg::lead_info_t li_held;
	utf8s_pkg::lead_info_t li_in;
	logic [7:0] lo;
	logic [7:0] hi;
	logic       in_range;
	logic       fresh;

	// Classify the byte against the held sequence
	always_comb begin
		li_held = utf8s_pkg::lead_info(pending_bytes_q[0]);
		li_in   = utf8s_pkg::lead_info(in_byte);
		lo = (pending_count_q == 2'd1) ? li_held.lo : utf8s_pkg::CONT_LO;
		hi = (pending_count_q == 2'd1) ? li_held.hi : utf8s_pkg::CONT_HI;
		in_range = (in_byte >= lo) && (in_byte <= hi);

		next_count  = pending_count_q;
		next_length = sequence_length_q;
		wr_en       = 3'b000;
		rep_cnt     = 3'd0;
		lit_cnt     = 3'd0;
		lits        = '0;
		fresh       = 1'b0;

		if (pending_count_q == 2'd0) begin
			fresh = 1'b1;
		end else if (in_range) begin
			if ({1'b0, pending_count_q} + 3'd1 >= sequence_length_q) begin
				// Complete sequence: copy held bytes and this one
				lit_cnt = {1'b0, pending_count_q} + 3'd1;
				lits[0] = pending_bytes_q[0];
				lits[1] = (pending_count_q > 2'd1) ? pending_bytes_q[1] : in_byte;
				lits[2] = (pending_count_q > 2'd2) ? pending_bytes_q[2] : in_byte;
				lits[3] = in_byte;
				next_count  = 2'd0;
				next_length = utf8s_pkg::SEQ_NONE;
			end else begin
				// Hold the continuation
				wr_en[pending_count_q] = 1'b1;
				next_count = pending_count_q + 2'd1;
			end
		end else begin
			// Broken sequence: one replacement per held byte, then restart on this byte
			rep_cnt = {1'b0, pending_count_q};
			fresh   = 1'b1;
		end

		// Start a new sequence with this byte
		if (fresh) begin
			next_count  = 2'd0;
			next_length = utf8s_pkg::SEQ_NONE;
			if (in_byte <= utf8s_pkg::ASCII_MAX) begin
				lit_cnt = 3'd1;
				lits[0] = in_byte;
			end else if (li_in.len == utf8s_pkg::SEQ_NONE) begin
				rep_cnt = rep_cnt + 3'd1;
			end else begin
				wr_en[0]    = 1'b1;
				next_count  = 2'd1;
				next_length = li_in.len;
			end
		end

		// Flush at end of message: each held byte becomes a replacement
		if (in_last) begin
			rep_cnt     = rep_cnt + {1'b0, next_count};
			next_count  = 2'd0;
			next_length = utf8s_pkg::SEQ_NONE;
		end
	end

	assign desc.rep_cnt  = rep_cnt;
	assign desc.lit_cnt  = lit_cnt;
	assign desc.lits     = lits;
	assign desc.last     = in_last;
	assign desc_nonempty = (rep_cnt != 3'd0) || (lit_cnt != 3'd0);

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_count_q   <= 2'd0;
			sequence_length_q <= utf8s_pkg::SEQ_NONE;
		end else if (accept) begin
			pending_count_q   <= next_count;
			sequence_length_q <= next_length;
		end
	end

	// Hold pending bytes
	always_ff @(posedge clk) begin
		if (accept && wr_en[0]) begin
			pending_bytes_q[0] <= in_byte;
		end
		if (accept && wr_en[1]) begin
			pending_bytes_q[1] <= in_byte;
		end
		if (accept && wr_en[2]) begin
			pending_bytes_q[2] <= in_byte;
		end
	end

endmodule

/* src/utf8s_emit.sv */
// Result sequencer: plays out one item's descriptor byte by byte into an output register.
`timescale 1ns / 1ps

module utf8s_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  utf8s_pkg::item_desc_t desc,
	input  logic                  desc_nonempty,
	output logic                  can_load,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  is_replacement,
	output logic                  out_last,
	output logic                  last_of_run
);

	logic            job_v_q;
	logic [2:0]      rep_left_q;
	logic [1:0]      phase_q;
	logic [2:0]      lit_left_q;
	logic [3:0][7:0] lits_q;
	logic            last_q;

	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_rep_q;
	logic       out_last_q;
	logic       out_run_q;

	logic       adv;
	logic       job_end;
	logic [7:0] emit_byte;
	logic       emit_rep;

	assign adv = job_v_q && (!out_v_q || !out_stall);
	assign job_end = (rep_left_q == 3'd1 && phase_q == utf8s_pkg::PHASE_LAST && lit_left_q == 3'd0)
		|| (rep_left_q == 3'd0 && lit_left_q == 3'd1);
	assign can_load = !job_v_q || (adv && job_end);

	// Select the next byte of the job
	always_comb begin
		emit_rep  = (rep_left_q != 3'd0);
		emit_byte = lits_q[0];
		if (emit_rep) begin
			unique case (phase_q)
				utf8s_pkg::PHASE_FIRST: emit_byte = utf8s_pkg::REPL_BYTE0;
				utf8s_pkg::PHASE_MID:   emit_byte = utf8s_pkg::REPL_BYTE1;
				default:                emit_byte = utf8s_pkg::REPL_BYTE2;
			endcase
		end
	end

	// Advance the job and load the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q    <= 1'b0;
			rep_left_q <= 3'd0;
			phase_q    <= utf8s_pkg::PHASE_FIRST;
			lit_left_q <= 3'd0;
			out_v_q    <= 1'b0;
		end else begin
			if (adv) begin
				out_v_q <= 1'b1;
				if (job_end) begin
					job_v_q <= 1'b0;
				end
				if (emit_rep) begin
					if (phase_q == utf8s_pkg::PHASE_LAST) begin
						phase_q    <= utf8s_pkg::PHASE_FIRST;
						rep_left_q <= rep_left_q - 3'd1;
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end else begin
					lit_left_q <= lit_left_q - 3'd1;
				end
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			if (load && can_load && desc_nonempty) begin
				job_v_q    <= 1'b1;
				rep_left_q <= desc.rep_cnt;
				phase_q    <= utf8s_pkg::PHASE_FIRST;
				lit_left_q <= desc.lit_cnt;
			end
		end
	end

	// Hold payload: literals shift down as they go out
	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= emit_byte;
			out_rep_q  <= emit_rep;
			out_last_q <= job_end && last_q;
			out_run_q  <= job_end;
			if (!emit_rep) begin
				lits_q <= {8'h00, lits_q[3:1]};
			end
		end
		if (load && can_load && desc_nonempty) begin
			lits_q <= desc.lits;
			last_q <= desc.last;
		end
	end

	assign out_valid      = out_v_q;
	assign out_byte       = out_byte_q;
	assign is_replacement = out_rep_q;
	assign out_last       = out_last_q;
	assign last_of_run    = out_run_q;

endmodule

/* src/utf8s_checker.sv */
// Port-level checks for the UTF-8 sanitizer, bound to the top level.
`timescale 1ns / 1ps

module utf8s_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       is_replacement,
	input logic       out_last,
	input logic       last_of_run
);

	// Message end always closes a run
	a_last_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> last_of_run)
		else $error("out_last without last_of_run");

	// Replacement bytes are only EF, BF or BD
	a_repl_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_replacement |->
		(out_byte == 8'hEF || out_byte == 8'hBF || out_byte == 8'hBD))
		else $error("bad replacement byte");

	// EF of a replacement is followed at once by BF
	a_repl_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && is_replacement && out_byte == 8'hEF |=>
		out_valid && is_replacement && out_byte == 8'hBF)
		else $error("replacement sequence broken");

	// Results of one item come without gaps
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("gap inside a run");

	// Stalled item holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
		&& $stable(is_replacement) && $stable(last_of_run))
		else $error("stalled output changed");

endmodule

bind utf8_sanitizer_top utf8s_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.out_byte       (out_byte),
	.is_replacement (is_replacement),
	.out_last       (out_last),
	.last_of_run    (last_of_run)
);

/* verif/testbench.sv */
// Self-checking testbench for the streaming UTF-8 sanitizer.
`timescale 1ns / 1ps

module testbench;

	localparam int RANDOM_ITEMS = 450;
	localparam int QUIET_TAIL   = 70;
	localparam int MAX_PER_ITEM = 12;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE       = 20;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [7:0] data;
		logic       repl;
		logic       msg_end;
		logic       run_end;
	} san_byte_t;

	// Tracks the sanitizer state and the bytes it still owes us
	class Utf8Scoreboard;
		logic [7:0] held[3];
		int         held_n;
		int         want_len;
		san_byte_t  step_q[$];
		san_byte_t  expected_q[$];
		int         errors;

		// Sequence length of a lead byte (0 if none) and range of its first continuation
		static function int lead_span(logic [7:0] c, output logic [7:0] lo,
				output logic [7:0] hi);
			lo = utf8s_pkg::CONT_LO;
			hi = utf8s_pkg::CONT_HI;
			if (c >= utf8s_pkg::LEAD2_LO && c <= utf8s_pkg::LEAD2_HI) return 2;
			if (c == utf8s_pkg::LEAD_E0) begin
				lo = utf8s_pkg::E0_CONT_LO;
				return 3;
			end
			if (c == utf8s_pkg::LEAD_ED) begin
				hi = utf8s_pkg::ED_CONT_HI;
				return 3;
			end
			if (c > utf8s_pkg::LEAD_E0 && c <= utf8s_pkg::LEAD3_HI) return 3;
			if (c == utf8s_pkg::LEAD_F0) begin
				lo = utf8s_pkg::F0_CONT_LO;
				return 4;
			end
			if (c == utf8s_pkg::LEAD_F4) begin
				hi = utf8s_pkg::F4_CONT_HI;
				return 4;
			end
			if (c > utf8s_pkg::LEAD_F0 && c < utf8s_pkg::LEAD_F4) return 4;
			return 0;
		endfunction

		function void emit(logic [7:0] b, logic rep);
			san_byte_t r;
			if (step_q.size() >= MAX_PER_ITEM) return;
			r.data = b;
			r.repl = rep;
			r.msg_end = 1'b0;
			r.run_end = 1'b0;
			step_q.push_back(r);
		endfunction

		function void emit_repl();
			emit(utf8s_pkg::REPL_BYTE0, 1'b1);
			emit(utf8s_pkg::REPL_BYTE1, 1'b1);
			emit(utf8s_pkg::REPL_BYTE2, 1'b1);
		endfunction

		// Treat a byte as the start of a new character
		function void begin_char(logic [7:0] x);
			logic [7:0] lo, hi;
			int n;
			if (x <= utf8s_pkg::ASCII_MAX) begin
				emit(x, 1'b0);
				return;
			end
			n = lead_span(x, lo, hi);
			if (n == 0) begin
				emit_repl();
				return;
			end
			held[0] = x;
			held_n = 1;
			want_len = n;
		endfunction

		function void consume(byte_q_t src);
			byte_q_t work;
			logic [7:0] x, lo, hi;
			int i;
			work = src;
			while (work.size() > 0) begin
				x = work.pop_front();
				lo = utf8s_pkg::CONT_LO;
				hi = utf8s_pkg::CONT_HI;
				if (held_n == 0) begin
					begin_char(x);
					continue;
				end
				if (held_n == 1) void'(lead_span(held[0], lo, hi));
				if (x >= lo && x <= hi) begin
					if (held_n + 1 >= want_len) begin
						for (i = 0; i < held_n; i++) emit(held[i], 1'b0);
						emit(x, 1'b0);
						held_n = 0;
						want_len = 0;
					end else begin
						held[held_n] = x;
						held_n++;
					end
				end else begin
					// Replace the lead, then re-examine held continuations and x as leads
					work.push_front(x);
					for (i = held_n - 1; i >= 1; i--) work.push_front(held[i]);
					emit_repl();
					held_n = 0;
					want_len = 0;
				end
			end
		endfunction

		// Message ended: replace what is held as a cut-off sequence
		function void flush_held();
			byte_q_t rest;
			int i;
			while (held_n > 0) begin
				rest.delete();
				for (i = 1; i < held_n; i++) rest.push_back(held[i]);
				emit_repl();
				held_n = 0;
				want_len = 0;
				consume(rest);
			end
		endfunction

		function void note_input(logic [7:0] b, logic l);
			byte_q_t one;
			step_q.delete();
			one.push_back(b);
			consume(one);
			if (l) flush_held();
			if (step_q.size() > 0) begin
				step_q[step_q.size() - 1].msg_end = l;
				step_q[step_q.size() - 1].run_end = 1'b1;
			end
			foreach (step_q[i]) expected_q.push_back(step_q[i]);
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		task check(san_byte_t got);
			san_byte_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("byte %h arrived with nothing pending", got.data));
				return;
			end
			want = expected_q.pop_front();
			if (got.data !== want.data)
				report($sformatf("out_byte %h, want %h", got.data, want.data));
			if (got.repl !== want.repl)
				report($sformatf("is_replacement %b, want %b (byte %h)",
					got.repl, want.repl, want.data));
			if (got.msg_end !== want.msg_end)
				report($sformatf("out_last %b, want %b (byte %h)",
					got.msg_end, want.msg_end, want.data));
			if (got.run_end !== want.run_end)
				report($sformatf("last_of_run %b, want %b (byte %h)",
					got.run_end, want.run_end, want.data));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       is_replacement;
	logic       out_last;
	logic       last_of_run;

	Utf8Scoreboard sb = new;
	byte_q_t       msg_q;
	int            sent;
	bit            quiet;
	int            cycles;

	utf8_sanitizer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.is_replacement(is_replacement),
		.out_last      (out_last),
		.last_of_run   (last_of_run)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watch both channels; inputs are noted before results are checked
	always @(posedge clk) begin
		san_byte_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_input(in_byte, in_last);
			if (out_valid && !out_stall) begin
				got.data = out_byte;
				got.repl = is_replacement;
				got.msg_end = out_last;
				got.run_end = last_of_run;
				sb.check(got);
			end
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Stall the output in random bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 11) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one item and hold it until accepted
	task send_byte(input logic [7:0] b, input logic l);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= l;
		do @(posedge clk); while (in_stall);
		sent++;
		if (sent >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
	endtask

	task send_message();
		foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
	endtask

	// Stop sending until every expected byte has come out
	task drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.expected_q.size() != 0);
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_lead();
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range(utf8s_pkg::LEAD2_LO, utf8s_pkg::LEAD2_HI));
			1: return 8'($urandom_range(utf8s_pkg::LEAD_E0, utf8s_pkg::LEAD3_HI));
			2: return 8'($urandom_range(utf8s_pkg::LEAD_F0, utf8s_pkg::LEAD_F4));
			3: return $urandom_range(0, 1) ? utf8s_pkg::LEAD_E0 : utf8s_pkg::LEAD_ED;
			4: return $urandom_range(0, 1) ? utf8s_pkg::LEAD_F0 : utf8s_pkg::LEAD_F4;
			default: return $urandom_range(0, 1) ? utf8s_pkg::LEAD2_LO : utf8s_pkg::LEAD2_HI;
		endcase
	endfunction

	// Append one character: mostly well formed, some noise and broken sequences
	function automatic void add_char();
		logic [7:0] lead, lo, hi, bad;
		int n, keep, i, kind;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			msg_q.push_back(8'($urandom_range(0, utf8s_pkg::ASCII_MAX)));
		end else if (kind < 40) begin
			msg_q.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 45) begin
			msg_q.push_back($urandom_range(0, 1)
				? 8'($urandom_range(utf8s_pkg::CONT_LO, utf8s_pkg::LEAD2_LO - 1))
				: 8'($urandom_range(utf8s_pkg::LEAD_F4 + 1, 255)));
		end else begin
			lead = pick_lead();
			n = Utf8Scoreboard::lead_span(lead, lo, hi);
			keep = (kind < 85) ? n - 1 : $urandom_range(0, n - 2);
			msg_q.push_back(lead);
			for (i = 0; i < keep; i++) begin
				if (i == 0) msg_q.push_back(8'($urandom_range(lo, hi)));
				else msg_q.push_back(8'($urandom_range(utf8s_pkg::CONT_LO,
					utf8s_pkg::CONT_HI)));
			end
			// Break the sequence, often just outside the allowed range
			if (keep < n - 1 && $urandom_range(0, 3) != 0) begin
				if (keep == 0 && $urandom_range(0, 1) == 0) begin
					bad = (lo > utf8s_pkg::CONT_LO) ? lo - 8'd1 : hi + 8'd1;
				end else begin
					do bad = 8'($urandom_range(0, 255));
					while (keep == 0 ? (bad >= lo && bad <= hi)
						: (bad >= utf8s_pkg::CONT_LO && bad <= utf8s_pkg::CONT_HI));
				end
				msg_q.push_back(bad);
			end
		end
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		in_last <= 1'b0;
		sent = 0;
		quiet = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, invalid leads, broken and cut-off sequences
		msg_q = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hC1, 8'hF5, 8'hC2, 8'h80,
			8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h90, 8'h80, 8'h80,
			8'hF4, 8'h90, 8'hF1, 8'h80, 8'h80, 8'h41, 8'hE1, 8'h80};
		send_message();
		drain();
		sent = 0;

		// Random messages
		while (sent < RANDOM_ITEMS) begin
			msg_q.delete();
			repeat ($urandom_range(1, 10)) add_char();
			send_message();
			if ($urandom_range(0, 15) == 0) drain();
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
